@@ sv/point_to_polar_quadrant_defines.svh @@
// Assertion macros shared by the point_to_polar_quadrant RTL.
`ifndef POINT_TO_POLAR_QUADRANT_DEFINES_SVH
`define POINT_TO_POLAR_QUADRANT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define PTPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define PTPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ptpq_pkg.sv @@
// Types and constants for the point-to-polar quadrant block.
package ptpq_pkg;

  localparam int CENTER_W        = 16;
  localparam int ANGLE_W         = 16;
  localparam int DIST_W          = 17;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int CFG_INDEX_W     = 1;

  localparam logic [DIST_W-1:0] DIST_MAX = 17'd92682;

  // atan(2^-i) in units of 2*pi/2^32
  localparam logic [31:0] ATAN_TURNS [0:ANGLE_TABLE_LEN-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CENTER_X = 1'd0,
    CFG_CENTER_Y = 1'd1
  } cfg_index_t;

  // 0: dx>0,dy>=0  1: dx<=0,dy>0  2: dx<0,dy<=0  3: dx>=0,dy<0
  typedef enum logic [1:0] {
    QUAD_XPOS = 2'd0,
    QUAD_YPOS = 2'd1,
    QUAD_XNEG = 2'd2,
    QUAD_YNEG = 2'd3
  } quad_t;

endpackage

@@ sv/point_to_polar_quadrant.sv @@
// Input register, quadrant fold and squaring, then stages with one CORDIC micro-rotation
//   and one root digit each (SQ_STEPS = max(COORD_BITS + 4, 16) + 1), then rounding.
// Throughput: one item per cycle while the skid stage is empty.
// A one-item skid behind the output register parks one result while another waits; then intake stalls.
// Reset (rst, synchronous) empties the pipeline and skid and sets both centres to 0.
`include "point_to_polar_quadrant_defines.svh"

module point_to_polar_quadrant #(
  parameter  int COORD_BITS    = 12,
  parameter  int CORDIC_STAGES = 16,
  localparam int IN_W          = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_FIELDS_W  = 2 * COORD_BITS + ptpq_pkg::ANGLE_W + ptpq_pkg::DIST_W + 3,
  localparam int OUT_W         = ((OUT_FIELDS_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [ptpq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ptpq_pkg::CENTER_W-1:0]    cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // point_x, point_y (low bits up), zero padded
  input  logic [IN_W-1:0]                  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // echo_x, echo_y, polar_angle, radial_distance, quadrant_code, at_center, zero padded
  output logic [OUT_W-1:0]                 m_tdata
);

  localparam int MAG_W    = (COORD_BITS + 4 > ptpq_pkg::CENTER_W) ? COORD_BITS + 4
                                                                   : ptpq_pkg::CENTER_W;
  localparam int DX_W     = MAG_W + 1;
  localparam int CW       = MAG_W + 19;
  localparam int SQ_STEPS = MAG_W + 1;
  localparam int S_W      = 2 * SQ_STEPS;
  localparam int REM_W    = SQ_STEPS + 2;
  localparam int NCS      = (CORDIC_STAGES > ptpq_pkg::ANGLE_TABLE_LEN)
                            ? ptpq_pkg::ANGLE_TABLE_LEN : CORDIC_STAGES;
  localparam int K_LAST   = (NCS + 1 > SQ_STEPS + 3) ? NCS + 1 : SQ_STEPS + 3;

  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    ptpq_pkg::quad_t       quad;
    logic                  ctr;
    logic [DX_W-1:0]       dx;
    logic [DX_W-1:0]       dy;
    logic [CW-1:0]         x;
    logic [CW-1:0]         y;
    logic [31:0]           z;
    logic [2*MAG_W-1:0]    sqx;
    logic [2*MAG_W-1:0]    sqy;
    logic [S_W-1:0]        s;
    logic [REM_W-1:0]      rem;
    logic [SQ_STEPS-1:0]   root;
    logic [SQ_STEPS:0]     distance;
  } stage_t;

  logic [ptpq_pkg::CENTER_W-1:0] center_x;
  logic [ptpq_pkg::CENTER_W-1:0] center_y;

  logic   en;
  stage_t nxt  [0:K_LAST];
  stage_t st   [0:K_LAST];
  logic   st_v [0:K_LAST];

  logic [31:0]                  angle_sum;
  logic [ptpq_pkg::ANGLE_W-1:0] angle_o;
  logic [ptpq_pkg::DIST_W-1:0]  dist_o;
  ptpq_pkg::quad_t              quad_o;
  logic [OUT_W-1:0]             res_data;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        ptpq_pkg::CFG_CENTER_X: center_x <= cfg_data;
        ptpq_pkg::CFG_CENTER_Y: center_y <= cfg_data;
      endcase
    end
  end

  assign s_tready = en;

  // offsets in 1/16 pixel
  always_comb begin
    nxt[0]    = '0;
    nxt[0].px = s_tdata[COORD_BITS-1:0];
    nxt[0].py = s_tdata[2*COORD_BITS-1:COORD_BITS];
    nxt[0].dx = DX_W'({nxt[0].px, 4'b0000}) - DX_W'(center_x);
    nxt[0].dy = DX_W'({nxt[0].py, 4'b0000}) - DX_W'(center_y);
  end

  for (genvar k = 1; k <= K_LAST; k++) begin : g_stage
    localparam int  CI       = (k >= 2) ? k - 2 : 0;
    localparam bit  DO_CORD  = (k >= 2) && (k - 2 < NCS);
    localparam bit  DO_SQRT  = (k >= 3) && (k - 3 < SQ_STEPS);
    localparam bit  DO_ROUND = (k == SQ_STEPS + 3);

    always_comb begin
      logic                   dx_pos, dx_neg, dy_pos, dy_neg;
      logic signed [DX_W-1:0] rx, ry;
      logic signed [2*DX_W-1:0] pxx, pyy;
      logic signed [CW-1:0]   xs, ys;
      logic [REM_W+1:0]       rem_t, trial;

      dx_pos = !st[k-1].dx[DX_W-1] && (st[k-1].dx != '0);
      dx_neg = st[k-1].dx[DX_W-1];
      dy_pos = !st[k-1].dy[DX_W-1] && (st[k-1].dy != '0);
      dy_neg = st[k-1].dy[DX_W-1];
      rx     = '0;
      ry     = '0;
      pxx    = '0;
      pyy    = '0;
      xs     = '0;
      ys     = '0;
      rem_t  = '0;
      trial  = '0;
      nxt[k] = st[k-1];

      if (k == 1) begin
        // fold into the first quadrant, square offsets for the distance
        priority if (dx_pos && !dy_neg) begin
          nxt[k].quad = ptpq_pkg::QUAD_XPOS;
          rx = $signed(st[k-1].dx);
          ry = $signed(st[k-1].dy);
        end else if (!dx_pos && dy_pos) begin
          nxt[k].quad = ptpq_pkg::QUAD_YPOS;
          rx = $signed(st[k-1].dy);
          ry = -$signed(st[k-1].dx);
        end else if (dx_neg && !dy_pos) begin
          nxt[k].quad = ptpq_pkg::QUAD_XNEG;
          rx = -$signed(st[k-1].dx);
          ry = -$signed(st[k-1].dy);
        end else begin
          nxt[k].quad = ptpq_pkg::QUAD_YNEG;
          rx = -$signed(st[k-1].dy);
          ry = $signed(st[k-1].dx);
        end
        nxt[k].ctr = (st[k-1].dx == '0) && (st[k-1].dy == '0);
        nxt[k].x   = {(CW-16)'(rx), 16'h0000};
        nxt[k].y   = {(CW-16)'(ry), 16'h0000};
        nxt[k].z   = '0;
        pxx        = $signed(st[k-1].dx) * $signed(st[k-1].dx);
        pyy        = $signed(st[k-1].dy) * $signed(st[k-1].dy);
        nxt[k].sqx = pxx[2*MAG_W-1:0];
        nxt[k].sqy = pyy[2*MAG_W-1:0];
      end

      if (k == 2) begin
        nxt[k].s    = S_W'(st[k-1].sqx) + S_W'(st[k-1].sqy);
        nxt[k].rem  = '0;
        nxt[k].root = '0;
      end

      if (DO_CORD) begin
        xs = $signed(st[k-1].x) >>> CI;
        ys = $signed(st[k-1].y) >>> CI;
        if (!st[k-1].y[CW-1]) begin
          nxt[k].x = st[k-1].x + ys;
          nxt[k].y = st[k-1].y - xs;
          nxt[k].z = st[k-1].z + ptpq_pkg::ATAN_TURNS[CI];
        end else begin
          nxt[k].x = st[k-1].x - ys;
          nxt[k].y = st[k-1].y + xs;
          nxt[k].z = st[k-1].z - ptpq_pkg::ATAN_TURNS[CI];
        end
      end

      if (DO_SQRT) begin
        // restoring square root, one root bit per stage
        rem_t = {st[k-1].rem, st[k-1].s[S_W-1 -: 2]};
        trial = (REM_W + 2)'({st[k-1].root, 2'b01});
        nxt[k].s = {st[k-1].s[S_W-3:0], 2'b00};
        if (rem_t >= trial) begin
          nxt[k].rem  = REM_W'(rem_t - trial);
          nxt[k].root = {st[k-1].root[SQ_STEPS-2:0], 1'b1};
        end else begin
          nxt[k].rem  = REM_W'(rem_t);
          nxt[k].root = {st[k-1].root[SQ_STEPS-2:0], 1'b0};
        end
      end

      if (DO_ROUND) begin
        nxt[k].distance = (SQ_STEPS + 1)'(st[k-1].root)
                        + (SQ_STEPS + 1)'(st[k-1].rem > REM_W'(st[k-1].root));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= K_LAST; k++) begin
        st_v[k] <= 1'b0;
      end
    end else if (en) begin
      st_v[0] <= s_tvalid;
      for (int k = 1; k <= K_LAST; k++) begin
        st_v[k] <= st_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= K_LAST; k++) begin
        st[k] <= nxt[k];
      end
    end
  end

  // round angle to 16 bits, saturate distance, clear angle, distance and quadrant at the centre
  always_comb begin
    angle_sum = {st[K_LAST].quad, 30'h0} + st[K_LAST].z + 32'h0000_8000;
    if (st[K_LAST].ctr) begin
      angle_o = '0;
      dist_o  = '0;
      quad_o  = ptpq_pkg::QUAD_XPOS;
    end else begin
      angle_o = angle_sum[31:16];
      quad_o  = st[K_LAST].quad;
      if (st[K_LAST].distance > (SQ_STEPS + 1)'(ptpq_pkg::DIST_MAX)) begin
        dist_o = ptpq_pkg::DIST_MAX;
      end else begin
        dist_o = st[K_LAST].distance[ptpq_pkg::DIST_W-1:0];
      end
    end
    res_data = OUT_W'({st[K_LAST].ctr, quad_o, dist_o, angle_o,
                       st[K_LAST].py, st[K_LAST].px});
  end

  ptpq_out_buf #(
    .DATA_W (OUT_W)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_v[K_LAST]),
    .in_ready  (en),
    .in_data   (res_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  `PTPQ_ASSERT_NOW(a_folded_quadrant, st_v[1], !st[1].x[CW-1] && !st[1].y[CW-1], "folded vector outside first quadrant")
  `PTPQ_ASSERT_NOW(a_centre_zero_dist, st_v[K_LAST] && st[K_LAST].ctr, st[K_LAST].distance == '0, "nonzero root at centre")
  `PTPQ_ASSERT_NEXT(a_stall_freeze, !en, $stable(st_v[K_LAST]) && $stable(st[K_LAST].z), "pipeline moved while stalled")

endmodule

@@ sv/ptpq_out_buf.sv @@
// Output register with a one-item skid stage for the result stream.
`include "point_to_polar_quadrant_defines.svh"

module ptpq_out_buf #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              skid_v;
  logic [DATA_W-1:0] skid_data;

  assign in_ready = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (out_ready) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end
    end else if (in_valid) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (in_valid) begin
      if (!out_valid || out_ready) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

  `PTPQ_ASSERT_NOW(a_skid_behind_out, skid_v, out_valid, "skid item held with empty output")
  `PTPQ_ASSERT_NEXT(a_stall_to_skid, in_valid && in_ready && out_valid && !out_ready, skid_v, "stalled item not parked")

endmodule
